// ----- design/kcc_pkg.sv -----
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants for the keypad code change controller.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int MASTER_DIGITS = 10;
	localparam int USER_DIGITS   = 5;
	localparam int BUF_DEPTH     = (MASTER_DIGITS > USER_DIGITS) ? MASTER_DIGITS : USER_DIGITS;
	localparam int DIGIT_W       = 4;
	localparam int POS_W         = 4;
	localparam int ULEN_W        = 3;
	localparam int MASTER_W      = 40;
	localparam int UCODE_W       = 20;
	localparam int KIND_W        = 2;
	localparam int EVENT_W       = 3;

	localparam int S_TDATA_W     = 8;
	localparam int M_TDATA_W     = 32;
	localparam int M_FIELDS_W    = 1 + POS_W + 1 + UCODE_W + ULEN_W;

	localparam logic [MASTER_W-1:0] MASTER_RESET = 40'h0987654321;
	localparam logic [UCODE_W-1:0]  UCODE_RESET  = 20'h12345;
	localparam logic [ULEN_W-1:0]   ULEN_RESET   = 3'd5;

	typedef enum logic [KIND_W-1:0] {
		KEY_DIGIT = 2'd0,
		KEY_BACK  = 2'd1,
		KEY_ENTER = 2'd2
	} key_kind_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_TAKEN     = 3'd0,
		EV_ERASED    = 3'd1,
		EV_TOO_LONG  = 3'd2,
		EV_WRONG     = 3'd3,
		EV_MASTER_OK = 3'd4,
		EV_SAVED     = 3'd5,
		EV_EXITED    = 3'd6
	} event_t;

	typedef enum logic {
		PH_MASTER = 1'b0,
		PH_USER   = 1'b1
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [DIGIT_W-1:0] digit;
	} item_t;

	typedef struct packed {
		event_t              ev;
		phase_t              phase_now;
		logic [POS_W-1:0]    cursor;
		logic                lock_changed;
		logic [UCODE_W-1:0]  user_code;
		logic [ULEN_W-1:0]   user_len;
	} result_t;

endpackage

// ----- design/kcc_entry_fsm.sv -----
// ----------------------------------------------------------------------------
// kcc_entry_fsm
// Phase state, entry buffer, stored user code and master code register;
// works out the next state and the result for one key press.
// ----------------------------------------------------------------------------
module kcc_entry_fsm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [kcc_pkg::MASTER_W-1:0] cfg_wr_data,
	input  logic                         step,
	input  kcc_pkg::item_t               item,
	output logic                         res_valid,
	output kcc_pkg::result_t             res
);
	import kcc_pkg::*;

	phase_t                phase_q, phase_d;
	logic [POS_W-1:0]      pos_q, pos_d;
	logic [DIGIT_W-1:0]    buf_q [BUF_DEPTH];
	logic [UCODE_W-1:0]    ucode_q, ucode_d;
	logic [ULEN_W-1:0]     ulen_q, ulen_d;
	logic                  lock_q, lock_d;
	logic [MASTER_W-1:0]   master_q;
	logic [POS_W-1:0]      limit;
	logic                  room;
	logic                  match;
	logic                  buf_we;
	event_t                ev;

	assign limit = (phase_q == PH_USER) ? POS_W'(USER_DIGITS) : POS_W'(MASTER_DIGITS);
	assign room  = (pos_q < limit);

	always_comb begin
		match = (pos_q == POS_W'(MASTER_DIGITS));
		for (int i = 0; i < MASTER_DIGITS; i++) begin
			if (buf_q[i] != master_q[DIGIT_W*i +: DIGIT_W])
				match = 1'b0;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (key_kind_t'(item.kind))
			KEY_BACK: begin
				if (pos_q == '0)
					phase_d = PH_MASTER;
			end
			KEY_ENTER: begin
				if (phase_q == PH_MASTER)
					phase_d = match ? PH_USER : PH_MASTER;
				else
					phase_d = PH_MASTER;
			end
			default: phase_d = phase_q;
		endcase
	end

	// position, buffer, user code and event
	always_comb begin
		pos_d     = pos_q;
		ucode_d   = ucode_q;
		ulen_d    = ulen_q;
		lock_d    = lock_q;
		buf_we    = 1'b0;
		ev        = EV_TAKEN;
		res_valid = 1'b1;
		case (key_kind_t'(item.kind))
			KEY_DIGIT: begin
				if (room) begin
					buf_we = 1'b1;
					pos_d  = pos_q + POS_W'(1);
					ev     = EV_TAKEN;
				end else begin
					pos_d = '0;
					ev    = EV_TOO_LONG;
				end
			end
			KEY_BACK: begin
				if (pos_q == '0) begin
					ev = EV_EXITED;
				end else begin
					pos_d = pos_q - POS_W'(1);
					ev    = EV_ERASED;
				end
			end
			KEY_ENTER: begin
				pos_d = '0;
				if (phase_q == PH_MASTER) begin
					ev = match ? EV_MASTER_OK : EV_WRONG;
				end else begin
					for (int i = 0; i < USER_DIGITS; i++)
						ucode_d[DIGIT_W*i +: DIGIT_W] = (POS_W'(i) < pos_q) ? buf_q[i] : '0;
					ulen_d = pos_q[ULEN_W-1:0];
					lock_d = 1'b1;
					ev     = EV_SAVED;
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

	always_comb begin
		res.ev           = ev;
		res.phase_now    = phase_d;
		res.cursor       = pos_d;
		res.lock_changed = lock_d;
		res.user_code    = ucode_d;
		res.user_len     = ulen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MASTER;
			pos_q    <= '0;
			ucode_q  <= UCODE_RESET;
			ulen_q   <= ULEN_RESET;
			lock_q   <= 1'b0;
			master_q <= MASTER_RESET;
		end else begin
			if (cfg_wr_en)
				master_q <= cfg_wr_data;
			if (step) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				ucode_q <= ucode_d;
				ulen_q  <= ulen_d;
				lock_q  <= lock_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			if (step && buf_we && pos_q == POS_W'(i))
				buf_q[i] <= item.digit;
		end
	end

endmodule

// ----- design/keypad_code_change_controller_core.sv -----
// ----------------------------------------------------------------------------
// keypad_code_change_controller_core
// Key press stream in, one status beat out per digit, backspace or enter key.
//
//   channel  dir  tdata                         tuser
//   s_*      in   digit                         key_kind
//   m_*      out  phase_now, cursor, lock_changed,
//                 user_code_out, user_len_out   event_res
//   cfg_*    in   master_code (write only)
//
// one key per cycle sustained while the output is not stalled; input register,
// then the state update and the result register, which offers the beat
// the single stored state update in the fsm sets that one-key-per-cycle rate
// reset clears phase, cursor and the new-lock flag and restores the default
// master and user codes; the entry buffer holds no reset value
// a stalled output holds the input register; s_tready drops only when both
// stages are full; key_kind 3 is taken and dropped without a beat
// ----------------------------------------------------------------------------
module keypad_code_change_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [kcc_pkg::MASTER_W-1:0]  cfg_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [kcc_pkg::S_TDATA_W-1:0] s_tdata,  // digit[3:0]
	input  logic [kcc_pkg::KIND_W-1:0]    s_tuser,  // key_kind[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [kcc_pkg::M_TDATA_W-1:0] m_tdata,  // phase_now[0], cursor[4:1],
	                                                // lock_changed[5], user_code_out[25:6],
	                                                // user_len_out[28:26]
	output logic [kcc_pkg::EVENT_W-1:0]   m_tuser   // event_res[2:0]
);
	import kcc_pkg::*;

	logic     valid_s1;
	item_t    item_s1;
	logic     valid_s2;
	result_t  res_s2;
	logic     adv_s1;
	logic     res_valid;
	result_t  res;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind  <= s_tuser;
			item_s1.digit <= s_tdata[DIGIT_W-1:0];
		end
	end

	kcc_entry_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (adv_s1),
		.item        (item_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= adv_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.ev;
	assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, res_s2.user_len, res_s2.user_code,
	                   res_s2.lock_changed, res_s2.cursor, res_s2.phase_now};

	a_ok_enters_user: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_MASTER_OK |-> res_s2.phase_now == PH_USER && res_s2.cursor == '0)
		else $error("master ok without user phase");

	a_saved_sets_lock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == EV_SAVED |-> res_s2.lock_changed && res_s2.phase_now == PH_MASTER
		&& res_s2.user_len <= ULEN_W'(USER_DIGITS))
		else $error("save beat inconsistent");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_s2.cursor <= POS_W'(MASTER_DIGITS))
		else $error("cursor past buffer end");

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res_valid |=> m_tvalid)
		else $error("result beat lost");

endmodule

// ----- tb/sv/tb_keypad_code_change_controller_core.sv -----
// ----------------------------------------------------------------------------
// tb_keypad_code_change_controller_core
// Self-checking bench for the keypad code change controller core. A short
// table of key presses covers exit, wrong code, user-phase overflow, the ignored
// key kind and an empty new code; random sessions follow under five master codes.
// Each beat is checked against its typed table row or an in-bench lock model.
// ----------------------------------------------------------------------------
module tb_keypad_code_change_controller_core;
	timeunit 1ns;
	timeprecision 1ps;

	import kcc_pkg::*;

	localparam logic [KIND_W-1:0] KEY_SPARE = 2'd3;
	localparam int PHASE_KEYS     = 190;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_LIMIT    = 1500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 40;
	localparam int TABLE_ROWS     = 23;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [DIGIT_W-1:0] digit;
		bit                 typed;
		result_t            want;
	} key_row_t;

	localparam result_t NO_WANT = '0;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [MASTER_W-1:0]   cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [KIND_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [EVENT_W-1:0]    m_tuser;

	keypad_code_change_controller_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// lock model state
	logic [MASTER_W-1:0] lk_master;
	phase_t              lk_phase;
	logic [POS_W-1:0]    lk_pos;
	logic [DIGIT_W-1:0]  lk_buf [BUF_DEPTH];
	logic [DIGIT_W-1:0]  lk_ucode [USER_DIGITS];
	logic [ULEN_W-1:0]   lk_ulen;
	logic                lk_newlock;

	result_t status_q [$];
	int      mismatches = 0;
	int      status_beats = 0;
	int      keys_sent = 0;
	int      burst_left = 0;
	bit      no_gaps = 1'b0;
	bit      hold_req = 1'b0;

	key_row_t key_table [TABLE_ROWS] = '{
		'{KEY_BACK,  4'd0, 1'b1, '{EV_EXITED, PH_MASTER, 4'd0, 1'b0, UCODE_RESET, ULEN_RESET}},
		'{KEY_ENTER, 4'd0, 1'b1, '{EV_WRONG, PH_MASTER, 4'd0, 1'b0, UCODE_RESET, ULEN_RESET}},
		'{KEY_SPARE, 4'd5, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd1, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd2, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd3, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd4, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd5, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd6, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd7, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd8, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd9, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd0, 1'b0, NO_WANT},
		'{KEY_ENTER, 4'd15, 1'b1, '{EV_MASTER_OK, PH_USER, 4'd0, 1'b0, UCODE_RESET, ULEN_RESET}},
		'{KEY_DIGIT, 4'd15, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd0, 1'b0, NO_WANT},
		'{KEY_BACK,  4'd7, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd9, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd9, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd9, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd9, 1'b0, NO_WANT},
		'{KEY_DIGIT, 4'd3, 1'b1, '{EV_TOO_LONG, PH_USER, 4'd0, 1'b0, UCODE_RESET, ULEN_RESET}},
		'{KEY_ENTER, 4'd0, 1'b1, '{EV_SAVED, PH_MASTER, 4'd0, 1'b1, 20'h0, 3'd0}}
	};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit press_key(input logic [KIND_W-1:0] kind,
			input logic [DIGIT_W-1:0] dig, output result_t status);
		int   limit;
		bit   match;
		logic [UCODE_W-1:0] packed_code;
		limit = (lk_phase == PH_USER) ? USER_DIGITS : MASTER_DIGITS;
		status = '0;
		case (kind)
			KEY_DIGIT: begin
				if (lk_pos < limit && lk_pos < BUF_DEPTH) begin
					lk_buf[lk_pos] = dig;
					lk_pos = lk_pos + 1'b1;
					status.ev = EV_TAKEN;
				end else begin
					lk_pos = '0;
					status.ev = EV_TOO_LONG;
				end
			end
			KEY_BACK: begin
				if (lk_pos == 0) begin
					lk_phase = PH_MASTER;
					status.ev = EV_EXITED;
				end else begin
					lk_pos = lk_pos - 1'b1;
					status.ev = EV_ERASED;
				end
			end
			KEY_ENTER: begin
				if (lk_phase == PH_MASTER) begin
					match = (lk_pos == MASTER_DIGITS);
					for (int i = 0; i < MASTER_DIGITS; i++)
						if (match && lk_buf[i] != lk_master[4*i +: 4])
							match = 1'b0;
					if (match) begin
						lk_phase = PH_USER;
						status.ev = EV_MASTER_OK;
					end else begin
						status.ev = EV_WRONG;
					end
				end else begin
					for (int i = 0; i < USER_DIGITS; i++)
						lk_ucode[i] = (i < lk_pos) ? lk_buf[i] : 4'd0;
					lk_ulen = lk_pos[ULEN_W-1:0];
					lk_newlock = 1'b1;
					lk_phase = PH_MASTER;
					status.ev = EV_SAVED;
				end
				lk_pos = '0;
			end
			default: return 1'b0;
		endcase
		packed_code = '0;
		for (int i = 0; i < USER_DIGITS; i++)
			packed_code[4*i +: 4] = lk_ucode[i];
		status.phase_now = lk_phase;
		status.cursor = lk_pos;
		status.lock_changed = lk_newlock;
		status.user_code = packed_code;
		status.user_len = lk_ulen;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at status beat %0d: %s got %0h want %0h",
				status_beats, what, got, want);
	endtask

	// status beat checker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ev = event_t'(m_tuser);
			got.phase_now = phase_t'(m_tdata[0]);
			got.cursor = m_tdata[4:1];
			got.lock_changed = m_tdata[5];
			got.user_code = m_tdata[25:6];
			got.user_len = m_tdata[28:26];
			if (status_q.size() == 0) begin
				report_mismatch("unexpected beat, event_res", got.ev, 0);
			end else begin
				want = status_q.pop_front();
				if (got.ev !== want.ev)
					report_mismatch("event_res", got.ev, want.ev);
				if (got.phase_now !== want.phase_now)
					report_mismatch("phase_now", got.phase_now, want.phase_now);
				if (got.cursor !== want.cursor)
					report_mismatch("cursor", got.cursor, want.cursor);
				if (got.lock_changed !== want.lock_changed)
					report_mismatch("lock_changed", got.lock_changed, want.lock_changed);
				if (got.user_code !== want.user_code)
					report_mismatch("user_code_out", got.user_code, want.user_code);
				if (got.user_len !== want.user_len)
					report_mismatch("user_len_out", got.user_len, want.user_len);
			end
			status_beats++;
		end
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int mode;
		int mode_left;
		mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		int quiet;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("keypad_code_change_controller_core regression: fail");
			$finish;
		end
	end

	task automatic pace();
		int gap;
		if (no_gaps)
			return;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_key(input logic [KIND_W-1:0] kind, input logic [DIGIT_W-1:0] dig,
			input bit typed, input result_t want);
		result_t predicted;
		bit      has;
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W-DIGIT_W){1'b0}}, dig};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		has = press_key(kind, dig, predicted);
		if (has)
			status_q.push_back(typed ? want : predicted);
		keys_sent++;
	endtask

	task automatic key(input logic [KIND_W-1:0] kind, input logic [DIGIT_W-1:0] dig);
		pace();
		send_key(kind, dig, 1'b0, NO_WANT);
	endtask

	task automatic wait_drained();
		int n;
		s_tvalid <= 1'b0;
		n = 0;
		while (status_q.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_master(input logic [MASTER_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= $urandom();
		lk_master = value;
	endtask

	// flaw 0 clean, 1 one digit changed, 2 one digit left out
	task automatic type_master(input int flaw);
		int   bad;
		int   i;
		logic [DIGIT_W-1:0] d;
		bad = $urandom_range(0, MASTER_DIGITS-1);
		for (i = 0; i < MASTER_DIGITS; i++) begin
			d = lk_master[4*i +: 4];
			if (flaw == 1 && i == bad)
				d = d ^ (4'd1 << $urandom_range(0, 3));
			if (!(flaw == 2 && i == bad)) begin
				if ($urandom_range(0, 9) == 0) begin
					key(KEY_DIGIT, $urandom_range(0, 15));
					key(KEY_BACK, $urandom_range(0, 15));
				end
				key(KEY_DIGIT, d);
			end
		end
		key(KEY_ENTER, $urandom_range(0, 15));
	endtask

	task automatic resync();
		if (lk_phase == PH_USER || lk_pos != 0)
			key(KEY_ENTER, $urandom_range(0, 15));
	endtask

	task automatic random_session();
		int sel;
		int sub;
		int n;
		int j;
		sel = $urandom_range(0, 15);
		if (sel <= 8) begin
			resync();
			type_master(0);
			sub = $urandom_range(0, 7);
			if (sub <= 4) begin
				n = $urandom_range(0, USER_DIGITS);
				for (j = 0; j < n; j++)
					key(KEY_DIGIT, $urandom_range(0, 15));
				if (n > 0 && $urandom_range(0, 3) == 0)
					key(KEY_BACK, $urandom_range(0, 15));
				key(KEY_ENTER, $urandom_range(0, 15));
			end else if (sub == 5) begin
				for (j = 0; j <= USER_DIGITS; j++)
					key(KEY_DIGIT, $urandom_range(0, 15));
				key(KEY_ENTER, $urandom_range(0, 15));
			end else if (sub == 6) begin
				n = $urandom_range(0, 3);
				for (j = 0; j < n; j++)
					key(KEY_DIGIT, $urandom_range(0, 15));
				for (j = 0; j <= n; j++)
					key(KEY_BACK, $urandom_range(0, 15));
			end
		end else if (sel <= 10) begin
			resync();
			type_master($urandom_range(1, 2));
		end else if (sel == 11) begin
			n = $urandom_range(MASTER_DIGITS+1, MASTER_DIGITS+3);
			for (j = 0; j < n; j++)
				key(KEY_DIGIT, $urandom_range(0, 15));
		end else if (sel <= 13) begin
			n = $urandom_range(3, 12);
			for (j = 0; j < n; j++)
				key($urandom_range(0, 3), $urandom_range(0, 15));
		end else if (sel == 14) begin
			key(KEY_BACK, $urandom_range(0, 15));
			key(KEY_BACK, $urandom_range(0, 15));
			key(KEY_SPARE, $urandom_range(0, 15));
		end else begin
			type_master(0);
		end
	endtask

	initial begin
		logic [MASTER_W-1:0] value;
		int  start;
		bit  held;
		bit  paused;
		lk_master = MASTER_RESET;
		lk_phase = PH_MASTER;
		lk_pos = '0;
		for (int i = 0; i < BUF_DEPTH; i++)
			lk_buf[i] = '0;
		for (int i = 0; i < USER_DIGITS; i++)
			lk_ucode[i] = 4'(USER_DIGITS - i);
		lk_ulen = ULEN_RESET;
		lk_newlock = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < TABLE_ROWS; r++) begin
			pace();
			send_key(key_table[r].kind, key_table[r].digit, key_table[r].typed,
				key_table[r].want);
		end

		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			value = '0;
			case (ph)
				0: for (int i = 0; i < MASTER_DIGITS; i++)
					value[4*i +: 4] = $urandom_range(0, 9);
				1: value = '0;
				2: value = 40'h9999999999;
				3: begin
					for (int i = 0; i < MASTER_DIGITS; i++)
						value[4*i +: 4] = $urandom_range(0, 15);
					value[MASTER_W-1 -: 4] = $urandom_range(0, 8);
				end
				default: value = MASTER_RESET;
			endcase
			write_master(value);
			start = keys_sent;
			while (keys_sent - start < PHASE_KEYS) begin
				if (ph == 2 && !held && keys_sent - start > 60) begin
					// fill both stages while the receiver holds off
					held = 1'b1;
					hold_req = 1'b1;
					no_gaps = 1'b1;
					repeat (40) key($urandom_range(0, 2), $urandom_range(0, 15));
					no_gaps = 1'b0;
				end
				if (ph == 3 && !paused && keys_sent - start > 80) begin
					paused = 1'b1;
					wait_drained();
				end
				random_session();
			end
		end

		wait_drained();
		if (status_q.size() != 0)
			report_mismatch("status beats missing", status_q.size(), 0);
		if (mismatches == 0)
			$display("keypad_code_change_controller_core regression: pass");
		else
			$display("keypad_code_change_controller_core regression: fail");
		$finish;
	end

endmodule
